// ===== rtl/core/dcptg_pkg.sv =====
// Shared types, codes and lookup tables for the two-voice tone generator.
package dcptg_pkg;

   localparam int unsigned LEVEL_W = 7;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_FREQ   = 2'd1;
   localparam logic [1:0] REG_VOLUME = 2'd2;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   localparam logic [1:0] FILT_NONE = 2'd0;
   localparam logic [1:0] FILT_AVG2 = 2'd1;

   localparam logic [7:0] MID_SAMPLE = 8'h80;

   // Bit i of each table is entry i.
   localparam logic [15:0] TAB_P4  = 16'b0111_0000_1010_0110;
   localparam logic [31:0] TAB_P5  = 32'b0110_0101_1011_1101_0100_0100_1110_0000;
   localparam logic [31:0] TAB_P5T = 32'b0010_1110_1100_0111_1100_1101_0010_0001;
   localparam logic [31:0] TAB_D31 = 32'h0008_0002;
   localparam logic [7:0]  TAB_D6  = 8'b0001_0010;

   typedef struct packed {
      logic       tick;
      logic       write;
      logic [1:0] kind;
      logic [7:0] data;
   } voice_ctl_type;

endpackage

// ===== rtl/core/dcptg_voice.sv =====
// One tone voice: registers, divider, polynomial counters and output level.
module dcptg_voice (
   input  logic                           clock,
   input  logic                           reset,
   input  dcptg_pkg::voice_ctl_type       ctl,
   output logic [dcptg_pkg::LEVEL_W-1:0]  level
);
   import dcptg_pkg::*;

   localparam logic [3:0] MODE_HOLD        = 4'd0;
   localparam logic [3:0] MODE_POLY4       = 4'd1;
   localparam logic [3:0] MODE_DIV31_POLY4 = 4'd2;
   localparam logic [3:0] MODE_POLY5_POLY4 = 4'd3;
   localparam logic [3:0] MODE_PURE_A      = 4'd4;
   localparam logic [3:0] MODE_PURE_B      = 4'd5;
   localparam logic [3:0] MODE_DIV31_A     = 4'd6;
   localparam logic [3:0] MODE_POLY5_A     = 4'd7;
   localparam logic [3:0] MODE_POLY9       = 4'd8;
   localparam logic [3:0] MODE_POLY5_B     = 4'd9;
   localparam logic [3:0] MODE_DIV31_B     = 4'd10;
   localparam logic [3:0] MODE_POLY5_SET   = 4'd11;
   localparam logic [3:0] MODE_DIV6_A      = 4'd12;
   localparam logic [3:0] MODE_DIV6_B      = 4'd13;
   localparam logic [3:0] MODE_DIV31_DIV6  = 4'd14;

   logic [3:0]         mode_ff,   mode_in;
   logic [4:0]         freq_ff,   freq_in;
   logic [LEVEL_W-1:0] vol_ff,    vol_in;
   logic [5:0]         count_ff,  count_in;
   logic [5:0]         reload_ff, reload_in;
   logic [3:0]         poly4_ff,  poly4_in;
   logic [4:0]         poly5_ff,  poly5_in;
   logic [2:0]         div6_ff,   div6_in;
   logic [8:0]         poly9_ff,  poly9_in;
   logic [LEVEL_W-1:0] level_ff,  level_in;

   logic [4:0]         p5n;
   logic [3:0]         p4n;
   logic [2:0]         d6n;
   logic [8:0]         p9n;
   logic [LEVEL_W-1:0] toggled;
   logic [LEVEL_W-1:0] p4_level;
   logic [LEVEL_W-1:0] d6_level;
   logic [5:0]         nv;

   always_comb begin
      mode_in   = mode_ff;
      freq_in   = freq_ff;
      vol_in    = vol_ff;
      count_in  = count_ff;
      reload_in = reload_ff;
      poly4_in  = poly4_ff;
      poly5_in  = poly5_ff;
      div6_in   = div6_ff;
      poly9_in  = poly9_ff;
      level_in  = level_ff;

      p5n      = (poly5_ff >= 5'd30) ? 5'd0 : poly5_ff + 5'd1;
      p4n      = (poly4_ff >= 4'd14) ? 4'd0 : poly4_ff + 4'd1;
      d6n      = (div6_ff >= 3'd5) ? 3'd0 : div6_ff + 3'd1;
      p9n      = {poly9_ff[0] ^ poly9_ff[4], poly9_ff[8:1]};
      toggled  = (level_ff == '0) ? vol_ff : '0;
      p4_level = TAB_P4[p4n] ? vol_ff : '0;
      d6_level = TAB_D6[d6n] ? toggled : level_ff;
      nv       = '0;

      if (ctl.write) begin
         case (ctl.kind)
            REG_MODE:   mode_in = ctl.data[3:0];
            REG_FREQ:   freq_in = ctl.data[4:0];
            REG_VOLUME: vol_in  = {ctl.data[3:0], 3'b000};
            default: ;
         endcase
         // re-arm divider
         if (mode_in == MODE_HOLD) begin
            nv       = '0;
            level_in = vol_in;
         end else begin
            nv = {1'b0, freq_in} + 6'd1;
         end
         if (nv != reload_ff) begin
            reload_in = nv;
            if (count_ff == '0 || nv == '0) begin
               count_in = nv;
            end
         end
      end else if (ctl.tick && count_ff != '0) begin
         if (count_ff > 6'd1) begin
            count_in = count_ff - 6'd1;
         end else begin
            count_in = reload_ff;
            poly5_in = p5n;
            case (mode_ff) inside
               MODE_HOLD: ;
               MODE_POLY4: begin
                  poly4_in = p4n;
                  level_in = p4_level;
               end
               MODE_DIV31_POLY4: begin
                  if (TAB_D31[p5n]) begin
                     poly4_in = p4n;
                     level_in = p4_level;
                  end
               end
               MODE_POLY5_POLY4: begin
                  if (TAB_P5T[p5n]) begin
                     poly4_in = p4n;
                     level_in = p4_level;
                  end
               end
               MODE_PURE_A, MODE_PURE_B: level_in = toggled;
               MODE_DIV31_A, MODE_DIV31_B: begin
                  if (TAB_D31[p5n]) level_in = toggled;
               end
               MODE_POLY5_A, MODE_POLY5_B: level_in = TAB_P5[p5n] ? vol_ff : '0;
               MODE_POLY9: begin
                  poly9_in = p9n;
                  level_in = p9n[0] ? vol_ff : '0;
               end
               MODE_POLY5_SET: begin
                  if (TAB_P5[p5n]) level_in = vol_ff;
               end
               MODE_DIV6_A, MODE_DIV6_B: begin
                  div6_in  = d6n;
                  level_in = d6_level;
               end
               MODE_DIV31_DIV6: begin
                  if (TAB_D31[p5n]) begin
                     div6_in  = d6n;
                     level_in = d6_level;
                  end
               end
               default: begin
                  if (TAB_P5T[p5n]) begin
                     div6_in  = d6n;
                     level_in = d6_level;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         freq_ff   <= '0;
         vol_ff    <= '0;
         count_ff  <= '0;
         reload_ff <= '0;
         poly4_ff  <= '0;
         poly5_ff  <= '0;
         div6_ff   <= '0;
         poly9_ff  <= 9'd1;
         level_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         freq_ff   <= freq_in;
         vol_ff    <= vol_in;
         count_ff  <= count_in;
         reload_ff <= reload_in;
         poly4_ff  <= poly4_in;
         poly5_ff  <= poly5_in;
         div6_ff   <= div6_in;
         poly9_ff  <= poly9_in;
         level_ff  <= level_in;
      end
   end

   // level after this cycle's update, used by the mixer on a tick
   assign level = level_in;

endmodule

// ===== rtl/core/dual_channel_poly_tone_generator_unit.sv =====
// Top level of the two-voice tone generator: request register, voices, mixer, filter.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   command, channel, reg_kind, write_data, paused
//   rsp_      out        rsp_valid / rsp_stall   sample
//   csr_      in         csr_valid / csr_ready   data (filter mode)
//
// One request per cycle while req_stall is low; a tick's sample goes to the output register.
// On a tick both voices update together in the cycle the request leaves the input register.
// Writes give no sample. csr_ready is always high.
// Reset is synchronous; it resets all voice state, filter mode and history, and both valids.
// A stalled sample holds in the output register; the input register keeps one
// more request, and req_stall rises only when both are full and rsp_stall is high.
module dual_channel_poly_tone_generator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_command,
   input  logic       req_channel,
   input  logic [1:0] req_reg_kind,
   input  logic [7:0] req_write_data,
   input  logic       req_paused,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_sample,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_data
);
   import dcptg_pkg::*;

   logic       valid_ff,   valid_in;
   logic       command_ff;
   logic       channel_ff;
   logic [1:0] kind_ff;
   logic [7:0] data_ff;
   logic       paused_ff;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] sample_ff,    sample_in;
   logic [7:0] prev_ff,      prev_in;
   logic [1:0] filter_ff,    filter_in;

   logic       advance;
   logic       fire;
   logic       tick;
   logic       write_ok;
   logic [7:0] raw;
   logic [8:0] pair_sum;
   logic [7:0] avg;

   voice_ctl_type      ctl [2];
   logic [LEVEL_W-1:0] lvl [2];

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = valid_ff && advance;
   assign tick      = fire && command_ff == CMD_TICK;
   assign write_ok  = fire && command_ff == CMD_WRITE && kind_ff != REG_UNUSED;
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_valid ? 1'b1 : (valid_ff && !advance);

   for (genvar c = 0; c < 2; c++) begin : g_voice
      always_comb begin
         ctl[c].tick  = tick;
         ctl[c].write = write_ok && channel_ff == 1'(c);
         ctl[c].kind  = kind_ff;
         ctl[c].data  = data_ff;
      end

      dcptg_voice u_voice (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl[c]),
         .level (lvl[c])
      );
   end

   always_comb begin
      raw       = paused_ff ? MID_SAMPLE : ({1'b0, lvl[0]} + {1'b0, lvl[1]});
      pair_sum  = {1'b0, prev_ff} + {1'b0, raw};
      avg       = pair_sum[8:1];
      sample_in = sample_ff;
      prev_in   = prev_ff;
      if (tick) begin
         if (filter_ff == FILT_NONE) begin
            sample_in = raw;
         end else begin
            sample_in = avg;
            prev_in   = (filter_ff == FILT_AVG2) ? raw : avg;
         end
      end
      out_valid_in = advance ? tick : out_valid_ff;
      filter_in    = csr_valid ? csr_data : filter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff      <= '0;
         filter_ff    <= FILT_NONE;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
         prev_ff      <= prev_in;
         filter_ff    <= filter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         command_ff <= req_command;
         channel_ff <= req_channel;
         kind_ff    <= req_reg_kind;
         data_ff    <= req_write_data;
         paused_ff  <= req_paused;
      end
      sample_ff <= sample_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = sample_ff;
   assign csr_ready  = 1'b1;

endmodule

// ===== rtl/core/dcptg_checker.sv =====
// Port-level assertions for the tone generator top level, with its bind.
module dcptg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_command,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_sample
);
   import dcptg_pkg::*;

   // stalled sample holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample))
      else $error("rsp sample dropped or changed while stalled");

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a new sample comes from an accepted tick request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_command == CMD_TICK, 2))
      else $error("sample without a matching tick request");

   // input side backs up only behind a stalled, full output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without output backpressure");

endmodule

bind dual_channel_poly_tone_generator_unit dcptg_checker u_dcptg_checker (.*);

// ===== dv/tb_dual_channel_poly_tone_generator_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the two-voice tone generator: random and directed requests.
module tb_dual_channel_poly_tone_generator_unit;
   import dcptg_pkg::*;

   localparam logic [1:0] FILT_HALF     = 2'd2;
   localparam logic [1:0] FILT_HALF_ALT = 2'd3;

   // bit i = entry i
   localparam bit [15:0] P4_SEQ  = 16'b0111_0000_1010_0110;
   localparam bit [31:0] P5_SEQ  = 32'b0110_0101_1011_1101_0100_0100_1110_0000;
   localparam bit [31:0] P5T_SEQ = 32'b0010_1110_1100_0111_1100_1101_0010_0001;
   localparam bit [31:0] D31_SEQ = 32'h0008_0002;
   localparam bit [7:0]  D6_SEQ  = 8'b0001_0010;

   localparam bit [11:0] FILTER_PLAN =
      {FILT_AVG2, FILT_HALF, FILT_NONE, FILT_HALF_ALT, FILT_HALF, FILT_AVG2};

   typedef enum bit [3:0] {
      MODE_HOLD    = 4'd0,  MODE_P4      = 4'd1,  MODE_P4_D31 = 4'd2,  MODE_P4_P5T = 4'd3,
      MODE_TOGGLE  = 4'd4,  MODE_TOGGLE2 = 4'd5,  MODE_D31    = 4'd6,  MODE_P5     = 4'd7,
      MODE_P9      = 4'd8,  MODE_P5_2    = 4'd9,  MODE_D31_2  = 4'd10, MODE_P5_SET = 4'd11,
      MODE_D6      = 4'd12, MODE_D6_2    = 4'd13, MODE_D6_D31 = 4'd14, MODE_D6_P5T = 4'd15
   } voice_mode_type;

   class tone_mix_predictor;
      bit [1:0] filter_sel;
      bit [3:0] mode_r[2];
      bit [4:0] freq_r[2];
      bit [6:0] vol_r[2];
      bit [5:0] div_cnt[2];
      bit [5:0] div_rld[2];
      bit [3:0] p4_pos[2];
      bit [4:0] p5_pos[2];
      bit [2:0] d6_pos[2];
      bit [8:0] lfsr9[2];
      bit [6:0] level[2];
      bit [7:0] hist;
      bit [7:0] expected_samples[$];
      int mismatches;

      function new();
         filter_sel = FILT_NONE;
         hist = 8'd0;
         mismatches = 0;
         for (int c = 0; c < 2; c++) begin
            mode_r[c] = 0; freq_r[c] = 0; vol_r[c] = 0;
            div_cnt[c] = 0; div_rld[c] = 0;
            p4_pos[c] = 0; p5_pos[c] = 0; d6_pos[c] = 0;
            lfsr9[c] = 9'd1; level[c] = 0;
         end
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      function void set_level_bit(int c, bit b);
         level[c] = b ? vol_r[c] : 7'd0;
      endfunction

      function void toggle_level(int c);
         level[c] = (level[c] == 7'd0) ? vol_r[c] : 7'd0;
      endfunction

      function void step_p4(int c);
         p4_pos[c] = p4_pos[c] + 4'd1;
         if (p4_pos[c] >= 4'd15) p4_pos[c] = 4'd0;
         set_level_bit(c, P4_SEQ[p4_pos[c]]);
      endfunction

      function void step_d6(int c);
         d6_pos[c] = d6_pos[c] + 3'd1;
         if (d6_pos[c] >= 3'd6) d6_pos[c] = 3'd0;
         if (D6_SEQ[d6_pos[c]]) toggle_level(c);
      endfunction

      function void apply_mode(int c);
         bit [4:0] p;
         bit [8:0] s;
         p = p5_pos[c];
         case (mode_r[c])
            MODE_HOLD: ;
            MODE_P4: step_p4(c);
            MODE_P4_D31: if (D31_SEQ[p]) step_p4(c);
            MODE_P4_P5T: if (P5T_SEQ[p]) step_p4(c);
            MODE_TOGGLE, MODE_TOGGLE2: toggle_level(c);
            MODE_D31, MODE_D31_2: if (D31_SEQ[p]) toggle_level(c);
            MODE_P5, MODE_P5_2: set_level_bit(c, P5_SEQ[p]);
            MODE_P9: begin
               s = lfsr9[c];
               s = {s[0] ^ s[4], s[8:1]};
               lfsr9[c] = s;
               set_level_bit(c, s[0]);
            end
            MODE_P5_SET: if (P5_SEQ[p]) level[c] = vol_r[c];
            MODE_D6, MODE_D6_2: step_d6(c);
            MODE_D6_D31: if (D31_SEQ[p]) step_d6(c);
            default: if (P5T_SEQ[p]) step_d6(c);
         endcase
      endfunction

      function void clock_voice(int c);
         if (div_cnt[c] == 6'd0) return;
         if (div_cnt[c] > 6'd1) begin
            div_cnt[c] = div_cnt[c] - 6'd1;
            return;
         end
         div_cnt[c] = div_rld[c];
         p5_pos[c] = p5_pos[c] + 5'd1;
         if (p5_pos[c] >= 5'd31) p5_pos[c] = 5'd0;
         apply_mode(c);
      endfunction

      function void rearm(int c);
         bit [5:0] nv;
         if (mode_r[c] == MODE_HOLD) begin
            nv = 6'd0;
            level[c] = vol_r[c];
         end else begin
            nv = {1'b0, freq_r[c]} + 6'd1;
         end
         if (nv != div_rld[c]) begin
            div_rld[c] = nv;
            if (div_cnt[c] == 6'd0 || nv == 6'd0) div_cnt[c] = nv;
         end
      endfunction

      function void absorb_request(bit cmd, bit ch, bit [1:0] kind, bit [7:0] data,
                                   bit paused);
         bit [7:0] raw;
         bit [8:0] total;
         if (cmd == CMD_WRITE) begin
            case (kind)
               REG_MODE:   mode_r[ch] = data[3:0];
               REG_FREQ:   freq_r[ch] = data[4:0];
               REG_VOLUME: vol_r[ch] = {data[3:0], 3'b000};
               default: return;
            endcase
            rearm(ch);
            return;
         end
         clock_voice(0);
         clock_voice(1);
         raw = {1'b0, level[0]} + {1'b0, level[1]};
         if (paused) raw = MID_SAMPLE;
         if (filter_sel != FILT_NONE) begin
            total = {1'b0, hist} + {1'b0, raw};
            hist = total[8:1];
            expected_samples.push_back(hist);
            if (filter_sel == FILT_AVG2) hist = raw;
         end else begin
            expected_samples.push_back(raw);
         end
      endfunction

      task check_sample(bit [7:0] got);
         bit [7:0] want;
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("sample %0d with none expected", got));
            return;
         end
         want = expected_samples.pop_front();
         if (got != want)
            report_mismatch($sformatf("sample %0d, expected %0d", got, want));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_command = CMD_TICK;
   logic       req_channel = 1'b0;
   logic [1:0] req_reg_kind = REG_MODE;
   logic [7:0] req_write_data = 8'd0;
   logic       req_paused = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_sample;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_data = FILT_NONE;

   int send_idle_pct = 26;
   int recv_stall_pct = 54;
   tone_mix_predictor mix_pred;

   dual_channel_poly_tone_generator_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_channel   (req_channel),
      .req_reg_kind  (req_reg_kind),
      .req_write_data(req_write_data),
      .req_paused    (req_paused),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample    (rsp_sample),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("dual_channel_poly_tone_generator_unit regression: fail");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) mix_pred.check_sample(rsp_sample);
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(bit cmd, bit ch, bit [1:0] kind, bit [7:0] data, bit paused);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_channel    <= ch;
      req_reg_kind   <= kind;
      req_write_data <= data;
      req_paused     <= paused;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mix_pred.absorb_request(cmd, ch, kind, data, paused);
      @(negedge clock);
   endtask

   task automatic send_tick(bit paused);
      send_request(CMD_TICK, 1'($urandom), 2'($urandom), 8'($urandom), paused);
   endtask

   task automatic send_write(bit ch, bit [1:0] kind, bit [7:0] data);
      send_request(CMD_WRITE, ch, kind, data, 1'($urandom));
   endtask

   task automatic drain_samples();
      req_valid <= 1'b0;
      while (mix_pred.expected_samples.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_filter(bit [1:0] sel);
      drain_samples();
      csr_valid <= 1'b1;
      csr_data  <= sel;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mix_pred.filter_sel = sel;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_burst(int count);
      int done;
      int r;
      int len;
      int k;
      bit ch;
      bit [1:0] kind;
      bit [7:0] data;
      done = 0;
      while (done < count) begin
         r = $urandom_range(99);
         if (r < 12) begin
            ch = 1'($urandom);
            k = $urandom_range(2);
            for (int i = 0; i < 3; i++) begin
               kind = 2'((k + i) % 3);
               data = 8'($urandom);
               if (kind == REG_FREQ && $urandom_range(99) < 70)
                  data[4:0] = 5'($urandom_range(3));
               send_write(ch, kind, data);
            end
            done += 3;
         end else if (r < 16) begin
            kind = 2'($urandom);
            send_write(1'($urandom), kind, 8'($urandom));
            if (kind != REG_UNUSED) done++;
         end else begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) send_tick($urandom_range(99) < 8);
            done += len;
         end
      end
   endtask

   initial begin
      mix_pred = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_tick(1'b0);
      send_tick(1'b1);
      send_write(1'b0, REG_UNUSED, 8'hff);
      send_write(1'b0, REG_VOLUME, 8'hff);
      send_write(1'b1, REG_VOLUME, 8'h0f);
      send_tick(1'b0);
      send_write(1'b0, REG_MODE, 8'hf1);
      send_write(1'b0, REG_FREQ, 8'he0);
      repeat (3) send_tick(1'b0);
      send_write(1'b1, REG_MODE, 8'h0f);
      send_write(1'b1, REG_FREQ, 8'h1f);
      send_write(1'b0, REG_MODE, 8'h08);
      repeat (3) send_tick(1'b0);
      send_write(1'b1, REG_MODE, 8'h00);
      send_write(1'b0, REG_VOLUME, 8'h00);
      send_tick(1'b1);
      send_tick(1'b0);

      for (int seg = 0; seg < 6; seg++) begin
         if (seg == 2) begin
            send_idle_pct = 54;
            recv_stall_pct = 26;
         end else if (seg == 4) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         write_filter(FILTER_PLAN[2*seg +: 2]);
         random_burst(320);
      end

      drain_samples();
      repeat (6) @(negedge clock);
      if (mix_pred.mismatches == 0 && mix_pred.expected_samples.size() == 0)
         $display("dual_channel_poly_tone_generator_unit regression: pass");
      else
         $display("dual_channel_poly_tone_generator_unit regression: fail");
      $finish;
   end

endmodule
